>>> src/swsc_pkg.sv
// Shared types, operation codes and status codes for the searchable stack.
package swsc_pkg;

  // Width of the depth_used result field.
  localparam int DEPTH_USED_W = 7;

  // Request modes.
  localparam logic [2:0] MODE_PUSH         = 3'd0;
  localparam logic [2:0] MODE_POP          = 3'd1;
  localparam logic [2:0] MODE_TOP          = 3'd2;
  localparam logic [2:0] MODE_SEARCH       = 3'd3;
  localparam logic [2:0] MODE_REMOVE_FIRST = 3'd4;
  localparam logic [2:0] MODE_REMOVE_EVENS = 3'd5;
  localparam logic [2:0] MODE_DEDUPE       = 3'd6;
  localparam logic [2:0] MODE_CLEAR        = 3'd7;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Datapath micro-operations issued by the controller.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
  localparam logic [OP_W-1:0] OP_LATCH      = 5'd1;
  localparam logic [OP_W-1:0] OP_PUSH       = 5'd2;
  localparam logic [OP_W-1:0] OP_RD_TOP     = 5'd3;
  localparam logic [OP_W-1:0] OP_POP        = 5'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 5'd5;
  localparam logic [OP_W-1:0] OP_A_TOP      = 5'd6;
  localparam logic [OP_W-1:0] OP_SCAN_DN    = 5'd7;
  localparam logic [OP_W-1:0] OP_SHIFT_INIT = 5'd8;
  localparam logic [OP_W-1:0] OP_SHIFT      = 5'd9;
  localparam logic [OP_W-1:0] OP_SHIFT_END  = 5'd10;
  localparam logic [OP_W-1:0] OP_SCAN_INIT  = 5'd11;
  localparam logic [OP_W-1:0] OP_EVENS      = 5'd12;
  localparam logic [OP_W-1:0] OP_SET_CNT_K  = 5'd13;
  localparam logic [OP_W-1:0] OP_DD_LOAD    = 5'd14;
  localparam logic [OP_W-1:0] OP_DD_CUR     = 5'd15;
  localparam logic [OP_W-1:0] OP_DD_KEEP_RD = 5'd16;
  localparam logic [OP_W-1:0] OP_DD_SCAN    = 5'd17;
  localparam logic [OP_W-1:0] OP_DD_KEEP    = 5'd18;
  localparam logic [OP_W-1:0] OP_DD_SKIP    = 5'd19;

  // One request.
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } in_t;

  // One result.
  typedef struct packed {
    logic signed [31:0]        data;
    logic [1:0]                status;
    logic [DEPTH_USED_W-1:0]   depth_used;
  } out_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            fin;     // latch the result for output
    logic [1:0]      st;      // status of the result
    logic            use_rd;  // result data comes from the read port
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic hit;        // word on the read port equals the request value
    logic dup;        // word on the read port equals the held word
    logic last_low;   // word on the read port is entry 0
    logic last_k;     // word on the read port is the last kept entry
    logic walk_done;  // upward walk has issued and drained every entry
    logic i_end;      // outer dedupe index reached the count
    logic k_zero;     // nothing kept yet
  } sts_t;

endpackage

>>> src/stack_with_search_and_compaction.sv
// Top level of the bounded stack with search and compaction.
//
//  channel  | ports                        | transfer
//  ---------+------------------------------+--------------------------------
//  request  | start, busy, in_data         | start high while busy is low
//  result   | out_valid, out_data          | out_valid high, one cycle
//
// Push, clear and refused requests finish in the dispatch step after the transfer; pop and
// top read the top entry there and finish in the top state. Search reads one entry a cycle
// down from the top; remove-first then shifts each entry above the match down by one place.
// Remove-evens walks up from the bottom and keeps the odd entries. Dedupe compares each entry
// with the entries kept so far and keeps it only if it is new. Reset clears the count, the
// output strobe and the controller state; the receiver cannot stall, so a result stands one cycle.
module stack_with_search_and_compaction #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  swsc_pkg::in_t  in_data,
  output logic           out_valid,
  output swsc_pkg::out_t out_data
);
  import swsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  swsc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_mode(in_data.mode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  swsc_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_value (in_data.value),
    .sts      (sts),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

>>> src/swsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/swsc_dp.sv
// Datapath: entry memory, count, scan pointers and result register.
module swsc_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swsc_pkg::cmd_t      cmd,
  input  logic signed [31:0]  in_value,
  output swsc_pkg::sts_t      sts,
  output logic                out_valid,
  output swsc_pkg::out_t      out_data
);
  import swsc_pkg::*;

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] a_r, a_nxt;     // next address to issue
  logic [CNT_W-1:0] d_r, d_nxt;     // index of the word on the read port
  logic             dv_r, dv_nxt;   // read port holds a word from a scan
  logic [CNT_W-1:0] k_r, k_nxt;     // write index of a compaction
  logic [CNT_W-1:0] i_r, i_nxt;     // outer dedupe index
  logic [31:0]      cur_r, cur_nxt;
  logic [31:0]      key_r, key_nxt;
  out_t             res_r, res_nxt;
  logic             out_valid_r;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic [31:0]      rd_data;

  swsc_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rd_data)
  );

  // Status toward the controller.
  always_comb begin
    sts.cnt_zero  = (cnt_r == '0);
    sts.cnt_full  = (cnt_r == CNT_FULL);
    sts.hit       = dv_r && (rd_data == key_r);
    sts.dup       = dv_r && (rd_data == cur_r);
    sts.last_low  = dv_r && (d_r == '0);
    sts.last_k    = dv_r && (d_r == (k_r - CNT_ONE));
    sts.walk_done = !dv_r && (a_r >= cnt_r);
    sts.i_end     = (i_r == cnt_r);
    sts.k_zero    = (k_r == '0);
  end

  // Micro-operation decode.
  always_comb begin
    cnt_nxt = cnt_r;
    a_nxt   = a_r;
    d_nxt   = d_r;
    dv_nxt  = 1'b0;
    k_nxt   = k_r;
    i_nxt   = i_r;
    cur_nxt = cur_r;
    key_nxt = key_r;
    we      = 1'b0;
    waddr   = k_r[IDX_W-1:0];
    wdata   = rd_data;
    re      = 1'b0;
    raddr   = a_r[IDX_W-1:0];
    unique case (cmd.op)
      OP_NOP: begin
      end
      OP_LATCH: begin
        key_nxt = in_value;
      end
      OP_PUSH: begin
        we      = 1'b1;
        waddr   = cnt_r[IDX_W-1:0];
        wdata   = key_r;
        cnt_nxt = cnt_r + CNT_ONE;
      end
      OP_RD_TOP: begin
        re    = 1'b1;
        raddr = IDX_W'(cnt_r - CNT_ONE);
      end
      OP_POP: begin
        cnt_nxt = cnt_r - CNT_ONE;
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      OP_A_TOP: begin
        a_nxt = cnt_r - CNT_ONE;
      end
      OP_SCAN_DN: begin
        re     = 1'b1;
        d_nxt  = a_r;
        dv_nxt = 1'b1;
        a_nxt  = a_r - CNT_ONE;
      end
      OP_SHIFT_INIT: begin
        a_nxt = d_r + CNT_ONE;
      end
      OP_SHIFT: begin
        // Move each word above the removed one down by one place.
        if (dv_r) begin
          we    = 1'b1;
          waddr = IDX_W'(d_r - CNT_ONE);
        end
        if (a_r < cnt_r) begin
          re     = 1'b1;
          d_nxt  = a_r;
          dv_nxt = 1'b1;
          a_nxt  = a_r + CNT_ONE;
        end
      end
      OP_SHIFT_END: begin
        cnt_nxt = cnt_r - CNT_ONE;
      end
      OP_SCAN_INIT: begin
        a_nxt = '0;
        k_nxt = '0;
        i_nxt = '0;
      end
      OP_EVENS: begin
        // Keep odd words, packed toward the bottom.
        if (dv_r && rd_data[0]) begin
          we    = 1'b1;
          k_nxt = k_r + CNT_ONE;
        end
        if (a_r < cnt_r) begin
          re     = 1'b1;
          d_nxt  = a_r;
          dv_nxt = 1'b1;
          a_nxt  = a_r + CNT_ONE;
        end
      end
      OP_SET_CNT_K: begin
        cnt_nxt = k_r;
      end
      OP_DD_LOAD: begin
        re    = 1'b1;
        raddr = i_r[IDX_W-1:0];
      end
      OP_DD_CUR: begin
        cur_nxt = rd_data;
        a_nxt   = '0;
      end
      OP_DD_KEEP_RD: begin
        we    = 1'b1;
        k_nxt = k_r + CNT_ONE;
        i_nxt = i_r + CNT_ONE;
      end
      OP_DD_SCAN: begin
        re     = 1'b1;
        d_nxt  = a_r;
        dv_nxt = 1'b1;
        a_nxt  = a_r + CNT_ONE;
      end
      OP_DD_KEEP: begin
        we    = 1'b1;
        wdata = cur_r;
        k_nxt = k_r + CNT_ONE;
        i_nxt = i_r + CNT_ONE;
      end
      OP_DD_SKIP: begin
        i_nxt = i_r + CNT_ONE;
      end
      default: begin
      end
    endcase
  end

  // Result assembled from the finishing command and the updated count.
  always_comb begin
    res_nxt            = res_r;
    if (cmd.fin) begin
      res_nxt.data       = cmd.use_rd ? rd_data : '0;
      res_nxt.status     = cmd.st;
      res_nxt.depth_used = DEPTH_USED_W'(cnt_nxt);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= cmd.fin;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    d_r   <= d_nxt;
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    cur_r <= cur_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // The count never goes past the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above capacity");

  // Only pop and top return data; here, any result with a failing status must report zero data.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status != ST_OK) |-> res_r.data == '0)
    else $error("nonzero data with a failing status");

  // After a result the controller returns to idle and each request needs a dispatch step, so strobes never touch.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobes in consecutive cycles");

endmodule

>>> src/swsc_ctrl.sv
// Controller: sequences each request as datapath micro-operations.
module swsc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2:0]     in_mode,
  input  swsc_pkg::sts_t sts,
  output swsc_pkg::cmd_t cmd,
  output logic           busy
);
  import swsc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_TOP     = 4'd2;
  localparam logic [3:0] S_FIND    = 4'd3;
  localparam logic [3:0] S_SHIFT   = 4'd4;
  localparam logic [3:0] S_EVENS   = 4'd5;
  localparam logic [3:0] S_DD_LOAD = 4'd6;
  localparam logic [3:0] S_DD_CUR  = 4'd7;
  localparam logic [3:0] S_DD_SCAN = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [2:0] mode_r, mode_nxt;

  // Next state and command.
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    cmd.op     = OP_NOP;
    cmd.fin    = 1'b0;
    cmd.st     = ST_OK;
    cmd.use_rd = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LATCH;
          mode_nxt  = in_mode;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        unique case (mode_r) inside
          MODE_PUSH: begin
            cmd.fin = 1'b1;
            if (sts.cnt_full) begin
              cmd.st = ST_FULL;
            end else begin
              cmd.op = OP_PUSH;
            end
          end
          MODE_POP, MODE_TOP: begin
            if (sts.cnt_zero) begin
              cmd.fin = 1'b1;
              cmd.st  = ST_EMPTY;
            end else begin
              cmd.op    = OP_RD_TOP;
              state_nxt = S_TOP;
            end
          end
          MODE_SEARCH, MODE_REMOVE_FIRST: begin
            if (sts.cnt_zero) begin
              cmd.fin = 1'b1;
              cmd.st  = ST_NOT_FOUND;
            end else begin
              cmd.op    = OP_A_TOP;
              state_nxt = S_FIND;
            end
          end
          MODE_REMOVE_EVENS: begin
            if (sts.cnt_zero) begin
              cmd.fin = 1'b1;
            end else begin
              cmd.op    = OP_SCAN_INIT;
              state_nxt = S_EVENS;
            end
          end
          MODE_DEDUPE: begin
            if (sts.cnt_zero) begin
              cmd.fin = 1'b1;
            end else begin
              cmd.op    = OP_SCAN_INIT;
              state_nxt = S_DD_LOAD;
            end
          end
          default: begin
            cmd.op  = OP_CLEAR;
            cmd.fin = 1'b1;
          end
        endcase
      end
      S_TOP: begin
        cmd.fin    = 1'b1;
        cmd.use_rd = 1'b1;
        cmd.op     = (mode_r == MODE_POP) ? OP_POP : OP_NOP;
        state_nxt  = S_IDLE;
      end
      // Walk down from the top until the first match or the bottom.
      S_FIND: begin
        if (sts.hit) begin
          if (mode_r == MODE_SEARCH) begin
            cmd.fin   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.op    = OP_SHIFT_INIT;
            state_nxt = S_SHIFT;
          end
        end else if (sts.last_low) begin
          cmd.fin   = 1'b1;
          cmd.st    = ST_NOT_FOUND;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_SCAN_DN;
        end
      end
      S_SHIFT: begin
        if (sts.walk_done) begin
          cmd.op    = OP_SHIFT_END;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_SHIFT;
        end
      end
      S_EVENS: begin
        if (sts.walk_done) begin
          cmd.op    = OP_SET_CNT_K;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_EVENS;
        end
      end
      // Dedupe: fetch the next word, then compare it with the kept words.
      S_DD_LOAD: begin
        if (sts.i_end) begin
          cmd.op    = OP_SET_CNT_K;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_DD_LOAD;
          state_nxt = S_DD_CUR;
        end
      end
      S_DD_CUR: begin
        if (sts.k_zero) begin
          cmd.op    = OP_DD_KEEP_RD;
          state_nxt = S_DD_LOAD;
        end else begin
          cmd.op    = OP_DD_CUR;
          state_nxt = S_DD_SCAN;
        end
      end
      S_DD_SCAN: begin
        if (sts.dup) begin
          cmd.op    = OP_DD_SKIP;
          state_nxt = S_DD_LOAD;
        end else if (sts.last_k) begin
          cmd.op    = OP_DD_KEEP;
          state_nxt = S_DD_LOAD;
        end else begin
          cmd.op = OP_DD_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_PUSH;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // A transfer on the input side always starts work.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not start");

  // Finishing a request frees the block on the next cycle.
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> !busy)
    else $error("block still busy after a result");

  // While idle the datapath only captures a request or does nothing.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (cmd.op == OP_NOP) || (cmd.op == OP_LATCH))
    else $error("datapath operation while idle");

endmodule
